[rtl/sbcf_pkg.sv]
package sbcf_pkg;

  // Default number of servo ids with a store entry (ids 1..MAX_ID).
  localparam int MAX_ID_DEF = 10;

  // Field widths.
  localparam int OP_W    = 3;
  localparam int ID_W    = 8;
  localparam int ANGLE_W = 17;
  localparam int CPT_W   = 16;
  localparam int POS_W   = 16;
  localparam int TRQ_W   = 11;
  localparam int BYTE_W  = 8;

  // Encoder counts per turn after reset.
  localparam logic [CPT_W-1:0] CPT_RESET = 16'd4096;

  // Angle to counts: round(|angle| * counts / 36000), halves away from zero.
  // The product is below 2^32, so the dividend fits in 32 bits.
  localparam int PROD_W    = 32;
  localparam int DIV_STEPS = 9;              // radix-4 steps, two quotient bits each
  localparam int DIV_BITS  = 2 * DIV_STEPS;  // low dividend bits fed to the steps
  localparam int TRIAL_W   = 18;
  localparam logic [PROD_W-1:0]  ROUND_HALF = 32'd18000;
  localparam logic [TRIAL_W-1:0] DIV_D1     = 18'd36000;
  localparam logic [TRIAL_W-1:0] DIV_D2     = 18'd72000;
  localparam logic [TRIAL_W-1:0] DIV_D3     = 18'd108000;

  // Operation codes of an input item.
  typedef enum logic [OP_W-1:0] {
    OP_MOVE     = 3'd0,
    OP_MOVE_ACC = 3'd1,
    OP_RD_POS   = 3'd2,
    OP_RD_TRQ   = 3'd3,
    OP_REPLY    = 3'd4,
    OP_QUERY    = 3'd5
  } op_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_TX    = 2'd0,
    KIND_REPLY = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

  // Packet bytes.
  localparam logic [BYTE_W-1:0] HDR_BYTE      = 8'hFF;
  localparam logic [BYTE_W-1:0] LEN_MOVE      = 8'h09;
  localparam logic [BYTE_W-1:0] LEN_MOVE_ACC  = 8'h0A;
  localparam logic [BYTE_W-1:0] LEN_READ      = 8'h04;
  localparam logic [BYTE_W-1:0] INS_WRITE     = 8'h03;
  localparam logic [BYTE_W-1:0] INS_READ      = 8'h02;
  localparam logic [BYTE_W-1:0] REG_GOAL      = 8'h2A;
  localparam logic [BYTE_W-1:0] REG_GOAL_ACC  = 8'h29;
  localparam logic [BYTE_W-1:0] REG_POSITION  = 8'h38;
  localparam logic [BYTE_W-1:0] REG_LOAD      = 8'h3C;
  localparam logic [BYTE_W-1:0] READ_LEN      = 8'h02;
  localparam logic [BYTE_W-1:0] ZERO_BYTE     = 8'h00;

  // Largest torque high byte that still carries a valid load value.
  localparam logic [BYTE_W-1:0] TRQ_HI_MAX    = 8'h07;

endpackage

[rtl/sbcf_a2c.sv]
module sbcf_a2c
  import sbcf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic signed [ANGLE_W-1:0] angle,
  input  logic [CPT_W-1:0]          counts,
  output logic                      done,
  output logic [POS_W-1:0]          pos
);

  typedef enum logic [1:0] {
    A_IDLE,
    A_LOAD,
    A_STEP
  } a2c_state_t;

  a2c_state_t          state_r;
  logic                done_r;
  logic                neg_r;
  logic [PROD_W-1:0]   prod_r;
  logic [PROD_W-1:0]   num_r;
  logic [POS_W-1:0]    rem_r;
  logic [POS_W-1:0]    quo_r;
  logic [3:0]          step_r;

  logic [ANGLE_W-1:0]  angle_bits;
  logic [ANGLE_W-1:0]  mag;
  logic [PROD_W:0]     prod_full;
  logic [PROD_W-1:0]   num_sum;
  logic [TRIAL_W-1:0]  trial;
  logic [TRIAL_W-1:0]  rem_diff;
  logic [1:0]          digit;
  logic [POS_W-1:0]    rem_nxt;

  // Magnitude of the angle; the most negative code still fits unsigned.
  assign angle_bits = angle;
  assign mag        = angle_bits[ANGLE_W-1] ? (~angle_bits + 1'b1) : angle_bits;
  assign prod_full  = {{(PROD_W+1-ANGLE_W){1'b0}}, mag} *
                      {{(PROD_W+1-CPT_W){1'b0}}, counts};
  assign num_sum    = prod_r + ROUND_HALF;

  // One radix-4 division step: pick the largest multiple of the divisor.
  assign trial = {rem_r, num_r[PROD_W-1 -: 2]};
  always_comb begin
    if (trial >= DIV_D3) begin
      digit    = 2'd3;
      rem_diff = trial - DIV_D3;
    end else if (trial >= DIV_D2) begin
      digit    = 2'd2;
      rem_diff = trial - DIV_D2;
    end else if (trial >= DIV_D1) begin
      digit    = 2'd1;
      rem_diff = trial - DIV_D1;
    end else begin
      digit    = 2'd0;
      rem_diff = trial;
    end
  end
  assign rem_nxt = rem_diff[POS_W-1:0];

  // Multiply, add the rounding half, then divide two bits a cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      case (state_r)
        A_IDLE: begin
          if (go) begin
            prod_r  <= prod_full[PROD_W-1:0];
            neg_r   <= angle_bits[ANGLE_W-1];
            done_r  <= 1'b0;
            state_r <= A_LOAD;
          end
        end
        A_LOAD: begin
          // The top dividend bits are below the divisor, so they seed the remainder.
          rem_r   <= {{(POS_W-(PROD_W-DIV_BITS)){1'b0}}, num_sum[PROD_W-1:DIV_BITS]};
          num_r   <= {num_sum[DIV_BITS-1:0], {(PROD_W-DIV_BITS){1'b0}}};
          quo_r   <= '0;
          step_r  <= '0;
          state_r <= A_STEP;
        end
        A_STEP: begin
          rem_r <= rem_nxt;
          num_r <= {num_r[PROD_W-3:0], 2'b00};
          quo_r <= {quo_r[POS_W-3:0], digit};
          if (step_r == 4'(DIV_STEPS - 1)) begin
            done_r  <= 1'b1;
            state_r <= A_IDLE;
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        default: begin
          state_r <= A_IDLE;
        end
      endcase
    end
  end

  assign done = done_r;
  assign pos  = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

[rtl/servo_bus_command_framer_unit.sv]
// A move packet comes out one byte a cycle, with a pause at the position bytes until the angle
// conversion is done. The block is busy, and takes no new command, until a packet has gone out,
// the byte that updates the store has passed the update state or a query has been answered.
// The angle conversion uses a 9-step radix-4 divider.
// Results cannot be stalled. Synchronous active-low reset clears the store through per-entry
// valid bits, disarms the reply decoder and sets counts per turn to 4096.
module servo_bus_command_framer_unit
  import sbcf_pkg::*;
#(
  parameter int MAX_ID = MAX_ID_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [OP_W-1:0]           in_operation,
  input  logic [ID_W-1:0]           in_servo_id,
  input  logic signed [ANGLE_W-1:0] in_angle_centideg,
  input  logic [15:0]               in_speed,
  input  logic [BYTE_W-1:0]         in_accel,
  input  logic [BYTE_W-1:0]         in_rx_byte,
  input  logic                      cfg_we,
  input  logic [CPT_W-1:0]          cfg_wdata,
  output logic                      out_valid,
  output logic [1:0]                out_kind,
  output logic [BYTE_W-1:0]         out_tx_byte,
  output logic                      out_last,
  output logic [ID_W-1:0]           out_reading_id,
  output logic [POS_W-1:0]          out_position_count,
  output logic signed [TRQ_W-1:0]   out_torque
);

  localparam int ADDR_W = (MAX_ID > 1) ? $clog2(MAX_ID) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TX,
    S_UPD,
    S_QRY
  } state_t;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_POS,
    PEND_TRQ
  } pend_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [TRQ_W-1:0] trq;
  } entry_t;

  // Control and payload registers.
  state_t              state_r;
  pend_t               pend_r;
  logic [ID_W-1:0]     pend_servo_r;
  logic [2:0]          reply_cnt_r;
  logic [BYTE_W-1:0]   reply_lo_r;
  logic [BYTE_W-1:0]   reply_hi_r;
  logic [CPT_W-1:0]    cpt_r;
  op_t                 pkt_r;
  logic [ID_W-1:0]     tx_id_r;
  logic [BYTE_W-1:0]   acc_r;
  logic [15:0]         spd_r;
  logic [3:0]          idx_r;
  logic [BYTE_W-1:0]   sum_r;
  logic [ID_W-1:0]     qry_id_r;

  logic                out_valid_r;
  kind_t               out_kind_r;
  logic [BYTE_W-1:0]   out_tx_r;
  logic                out_last_r;
  logic [ID_W-1:0]     out_id_r;
  logic [POS_W-1:0]    out_pos_r;
  logic [TRQ_W-1:0]    out_trq_r;

  // Store: one synchronous memory plus a valid bit per entry.
  entry_t              store_mem [MAX_ID];
  logic [MAX_ID-1:0]   vld_r;
  entry_t              rd_entry_r;
  logic                rd_hit_r;

  logic                accept;
  op_t                 op;
  logic                id_ok;
  logic [ID_W-1:0]     rd_id;
  logic [ID_W-1:0]     rd_id_m1;
  logic [ADDR_W-1:0]   rd_addr;
  logic                rd_in_range;
  logic [ID_W-1:0]     pend_m1;
  logic [ADDR_W-1:0]   wr_addr;
  logic                wr_en;
  entry_t              old_entry;
  entry_t              new_entry;
  logic [9:0]          trq_mag;
  logic [TRQ_W-1:0]    trq_val;

  logic                a2c_go;
  logic                pos_done;
  logic [POS_W-1:0]    pos_counts;

  logic [3:0]          last_idx;
  logic                need_pos;
  logic                tx_stall;
  logic                tx_is_last;
  logic [BYTE_W-1:0]   tx_data;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign op     = op_t'(in_operation);
  assign id_ok  = (in_servo_id != '0) && (in_servo_id <= ID_W'(MAX_ID));
  assign a2c_go = accept && ((op == OP_MOVE) || (op == OP_MOVE_ACC));

  // Angle to position counts.
  sbcf_a2c u_a2c (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (a2c_go),
    .angle  (in_angle_centideg),
    .counts (cpt_r),
    .done   (pos_done),
    .pos    (pos_counts)
  );

  // Read address: the armed servo for reply bytes, the given id otherwise.
  assign rd_id       = (op == OP_REPLY) ? pend_servo_r : in_servo_id;
  assign rd_id_m1    = rd_id - 8'd1;
  assign rd_addr     = rd_id_m1[ADDR_W-1:0];
  assign rd_in_range = (rd_id != '0) && (rd_id <= ID_W'(MAX_ID));

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_entry_r <= store_mem[rd_addr];
      rd_hit_r   <= rd_in_range ? vld_r[rd_addr] : 1'b0;
    end
  end

  // Reply decode: merge the new reading into the entry read in the cycle before the update.
  // The block is busy during the update, so no other access can reach the entry.
  assign pend_m1   = pend_servo_r - 8'd1;
  assign wr_addr   = pend_m1[ADDR_W-1:0];
  assign wr_en     = (state_r == S_UPD);
  assign old_entry = rd_hit_r ? rd_entry_r : '0;
  assign trq_mag   = {reply_hi_r[1:0], reply_lo_r};
  assign trq_val   = reply_hi_r[2] ? (~{1'b0, trq_mag} + 1'b1) : {1'b0, trq_mag};

  always_comb begin
    new_entry = old_entry;
    if (pend_r == PEND_POS) begin
      new_entry.pos = {reply_hi_r, reply_lo_r};
    end else if (reply_hi_r <= TRQ_HI_MAX) begin
      new_entry.trq = trq_val;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Packet byte at the current index; the final byte is the checksum.
  always_comb begin
    case (pkt_r)
      OP_MOVE:     last_idx = 4'd12;
      OP_MOVE_ACC: last_idx = 4'd13;
      default:     last_idx = 4'd7;
    endcase
  end

  assign tx_is_last = (idx_r == last_idx);
  assign need_pos   = ((pkt_r == OP_MOVE) && ((idx_r == 4'd6) || (idx_r == 4'd7))) ||
                      ((pkt_r == OP_MOVE_ACC) && ((idx_r == 4'd7) || (idx_r == 4'd8)));
  assign tx_stall   = need_pos && !pos_done;

  always_comb begin
    tx_data = ~sum_r;
    case (pkt_r)
      OP_MOVE: begin
        case (idx_r)
          4'd0, 4'd1: tx_data = HDR_BYTE;
          4'd2:       tx_data = tx_id_r;
          4'd3:       tx_data = LEN_MOVE;
          4'd4:       tx_data = INS_WRITE;
          4'd5:       tx_data = REG_GOAL;
          4'd6:       tx_data = pos_counts[7:0];
          4'd7:       tx_data = pos_counts[15:8];
          4'd8, 4'd9: tx_data = ZERO_BYTE;
          4'd10:      tx_data = spd_r[7:0];
          4'd11:      tx_data = spd_r[15:8];
          default:    tx_data = ~sum_r;
        endcase
      end
      OP_MOVE_ACC: begin
        case (idx_r)
          4'd0, 4'd1:  tx_data = HDR_BYTE;
          4'd2:        tx_data = tx_id_r;
          4'd3:        tx_data = LEN_MOVE_ACC;
          4'd4:        tx_data = INS_WRITE;
          4'd5:        tx_data = REG_GOAL_ACC;
          4'd6:        tx_data = acc_r;
          4'd7:        tx_data = pos_counts[7:0];
          4'd8:        tx_data = pos_counts[15:8];
          4'd9, 4'd10: tx_data = ZERO_BYTE;
          4'd11:       tx_data = spd_r[7:0];
          4'd12:       tx_data = spd_r[15:8];
          default:     tx_data = ~sum_r;
        endcase
      end
      default: begin
        case (idx_r)
          4'd0, 4'd1: tx_data = HDR_BYTE;
          4'd2:       tx_data = tx_id_r;
          4'd3:       tx_data = LEN_READ;
          4'd4:       tx_data = INS_READ;
          4'd5:       tx_data = (pkt_r == OP_RD_POS) ? REG_POSITION : REG_LOAD;
          4'd6:       tx_data = READ_LEN;
          default:    tx_data = ~sum_r;
        endcase
      end
    endcase
  end

  // Main sequencer with registered result outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_r       <= PEND_NONE;
      pend_servo_r <= '0;
      reply_cnt_r  <= '0;
      reply_lo_r   <= '0;
      cpt_r        <= CPT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        cpt_r <= cfg_wdata;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (op)
              OP_MOVE, OP_MOVE_ACC: begin
                pend_r      <= PEND_NONE;
                reply_cnt_r <= '0;
                pkt_r       <= op;
                tx_id_r     <= in_servo_id;
                acc_r       <= in_accel;
                spd_r       <= in_speed;
                idx_r       <= '0;
                sum_r       <= '0;
                state_r     <= S_TX;
              end
              OP_RD_POS, OP_RD_TRQ: begin
                if (id_ok) begin
                  pend_r       <= (op == OP_RD_POS) ? PEND_POS : PEND_TRQ;
                  pend_servo_r <= in_servo_id;
                  reply_cnt_r  <= '0;
                  pkt_r        <= op;
                  tx_id_r      <= in_servo_id;
                  idx_r        <= '0;
                  sum_r        <= '0;
                  state_r      <= S_TX;
                end
              end
              OP_REPLY: begin
                if (pend_r != PEND_NONE) begin
                  if (reply_cnt_r == 3'd5) begin
                    reply_lo_r  <= in_rx_byte;
                    reply_cnt_r <= reply_cnt_r + 3'd1;
                  end else if (reply_cnt_r == 3'd6) begin
                    reply_hi_r  <= in_rx_byte;
                    reply_cnt_r <= reply_cnt_r + 3'd1;
                    state_r     <= S_UPD;
                  end else if (reply_cnt_r == 3'd7) begin
                    pend_r      <= PEND_NONE;
                    reply_cnt_r <= '0;
                  end else begin
                    reply_cnt_r <= reply_cnt_r + 3'd1;
                  end
                end
              end
              OP_QUERY: begin
                qry_id_r <= in_servo_id;
                state_r  <= S_QRY;
              end
              default: begin
              end
            endcase
          end
        end
        S_TX: begin
          if (!tx_stall) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_TX;
            out_tx_r    <= tx_data;
            out_last_r  <= tx_is_last;
            out_id_r    <= '0;
            out_pos_r   <= '0;
            out_trq_r   <= '0;
            if (idx_r >= 4'd2) begin
              sum_r <= sum_r + tx_data;
            end
            if (tx_is_last) begin
              state_r <= S_IDLE;
            end else begin
              idx_r <= idx_r + 4'd1;
            end
          end
        end
        S_UPD: begin
          out_valid_r <= 1'b1;
          out_kind_r  <= KIND_REPLY;
          out_tx_r    <= '0;
          out_last_r  <= 1'b0;
          out_id_r    <= pend_servo_r;
          out_pos_r   <= new_entry.pos;
          out_trq_r   <= new_entry.trq;
          state_r     <= S_IDLE;
        end
        S_QRY: begin
          out_valid_r <= 1'b1;
          out_kind_r  <= KIND_QUERY;
          out_tx_r    <= '0;
          out_last_r  <= 1'b0;
          out_id_r    <= qry_id_r;
          out_pos_r   <= old_entry.pos;
          out_trq_r   <= old_entry.trq;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_tx_byte        = out_tx_r;
  assign out_last           = out_last_r;
  assign out_reading_id     = out_id_r;
  assign out_position_count = out_pos_r;
  assign out_torque         = out_trq_r;

  // An armed decoder always points at a servo that has a store entry.
  a_pend_servo_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != PEND_NONE) |-> ((pend_servo_r != '0) && (pend_servo_r <= ID_W'(MAX_ID))))
    else $error("armed reply decoder points outside the store");

  // No packet byte goes out while the position bytes wait for the divider.
  a_stall_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_TX) && tx_stall) |=> (!out_valid_r && $stable(idx_r)))
    else $error("packet byte emitted before the position was ready");

  // A store update is always followed by its decoded-reply transfer.
  a_upd_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |=> (out_valid_r && (out_kind_r == KIND_REPLY) && (state_r == S_IDLE)))
    else $error("store update without a reply transfer");

  // Only packet bytes carry the end-of-packet flag.
  a_last_is_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_kind_r == KIND_TX))
    else $error("end-of-packet flag on a non-packet transfer");

endmodule

[tb/tb_servo_bus_command_framer_unit.sv]
module tb_servo_bus_command_framer_unit;
  import sbcf_pkg::*;

  // Operation codes that the block ignores.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  // Positions within an 8-byte reply.
  localparam int REPLY_LOW_POS  = 5;
  localparam int REPLY_HIGH_POS = 6;
  localparam int REPLY_END_POS  = 7;

  localparam int DRAIN_LIMIT = 4000;

  // What the reply decoder is armed for.
  typedef enum logic [1:0] {
    ARM_NONE = 2'd0,
    ARM_POS  = 2'd1,
    ARM_TRQ  = 2'd2
  } arm_t;

  typedef struct {
    logic [OP_W-1:0]           op;
    logic [ID_W-1:0]           id;
    logic signed [ANGLE_W-1:0] angle;
    logic [15:0]               speed;
    logic [BYTE_W-1:0]         accel;
    logic [BYTE_W-1:0]         rx;
  } servo_cmd_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] tx;
    logic              last;
    logic [ID_W-1:0]   id;
    logic [POS_W-1:0]  pos;
    logic [TRQ_W-1:0]  trq;
  } bus_result_t;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [OP_W-1:0]           in_operation = OP_QUERY;
  logic [ID_W-1:0]           in_servo_id = '0;
  logic signed [ANGLE_W-1:0] in_angle_centideg = '0;
  logic [15:0]               in_speed = '0;
  logic [BYTE_W-1:0]         in_accel = '0;
  logic [BYTE_W-1:0]         in_rx_byte = '0;
  logic                      cfg_we = 1'b0;
  logic [CPT_W-1:0]          cfg_wdata = '0;
  logic                      out_valid;
  logic [1:0]                out_kind;
  logic [BYTE_W-1:0]         out_tx_byte;
  logic                      out_last;
  logic [ID_W-1:0]           out_reading_id;
  logic [POS_W-1:0]          out_position_count;
  logic signed [TRQ_W-1:0]   out_torque;

  servo_cmd_t  cmd_q[$];
  bus_result_t predicted_out_q[$];

  // Predictor state.
  logic [CPT_W-1:0]  cpt_model;
  logic [POS_W-1:0]  pos_store [1:MAX_ID_DEF];
  logic [TRQ_W-1:0]  trq_store [1:MAX_ID_DEF];
  arm_t              armed;
  int                pend_servo;
  int                reply_cnt;
  logic [BYTE_W-1:0] reply_lo;
  logic [BYTE_W-1:0] pkt [0:13];
  int                pkt_len;

  int errors = 0;
  int n_packets = 0;
  int n_decoded = 0;
  int n_answers = 0;
  int n_accepted = 0;
  int burst_left = 0;
  int gap_left = 0;

  servo_bus_command_framer_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_servo_id        (in_servo_id),
    .in_angle_centideg  (in_angle_centideg),
    .in_speed           (in_speed),
    .in_accel           (in_accel),
    .in_rx_byte         (in_rx_byte),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_kind           (out_kind),
    .out_tx_byte        (out_tx_byte),
    .out_last           (out_last),
    .out_reading_id     (out_reading_id),
    .out_position_count (out_position_count),
    .out_torque         (out_torque)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic flag_error(string msg);
    errors++;
    if (errors <= 10) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  // Angle in centidegrees to encoder counts, halves rounded away from zero.
  function automatic logic [POS_W-1:0] angle_counts(logic signed [ANGLE_W-1:0] ang,
                                                    logic [CPT_W-1:0] cpt);
    longint            a;
    longint unsigned   mag;
    longint unsigned   q;
    a = ang;
    mag = (a < 0) ? -a : a;
    q = (mag * cpt + 64'd18000) / 64'd36000;
    if (a < 0) begin
      q = -q;
    end
    return q[POS_W-1:0];
  endfunction

  task automatic push_result(kind_t k, logic [BYTE_W-1:0] tx, logic lst, logic [ID_W-1:0] id,
                             logic [POS_W-1:0] p, logic [TRQ_W-1:0] t);
    bus_result_t r;
    r.kind = k;
    r.tx = tx;
    r.last = lst;
    r.id = id;
    r.pos = p;
    r.trq = t;
    predicted_out_q.push_back(r);
  endtask

  task automatic put_byte(logic [BYTE_W-1:0] b);
    pkt[pkt_len] = b;
    pkt_len++;
  endtask

  // Emit the packet bytes followed by the inverted low byte of the sum from id on.
  task automatic send_packet();
    logic [BYTE_W-1:0] sum;
    sum = '0;
    for (int i = 2; i < pkt_len; i++) begin
      sum = sum + pkt[i];
    end
    for (int i = 0; i < pkt_len; i++) begin
      push_result(KIND_TX, pkt[i], 1'b0, '0, '0, '0);
    end
    push_result(KIND_TX, ~sum, 1'b1, '0, '0, '0);
  endtask

  task automatic reset_model();
    cpt_model = CPT_RESET;
    for (int i = 1; i <= MAX_ID_DEF; i++) begin
      pos_store[i] = '0;
      trq_store[i] = '0;
    end
    armed = ARM_NONE;
    pend_servo = 0;
    reply_cnt = 0;
    reply_lo = '0;
    predicted_out_q.delete();
  endtask

  // Work out the results of one accepted command and update the predicted state.
  task automatic predict_command(servo_cmd_t c);
    logic [POS_W-1:0] cnt;
    logic [TRQ_W-1:0] mag;
    logic [POS_W-1:0] p;
    logic [TRQ_W-1:0] t;
    pkt_len = 0;
    case (c.op)
      OP_MOVE, OP_MOVE_ACC: begin
        cnt = angle_counts(c.angle, cpt_model);
        armed = ARM_NONE;
        reply_cnt = 0;
        put_byte(HDR_BYTE);
        put_byte(HDR_BYTE);
        put_byte(c.id);
        put_byte((c.op == OP_MOVE) ? LEN_MOVE : LEN_MOVE_ACC);
        put_byte(INS_WRITE);
        put_byte((c.op == OP_MOVE) ? REG_GOAL : REG_GOAL_ACC);
        if (c.op == OP_MOVE_ACC) begin
          put_byte(c.accel);
        end
        put_byte(cnt[7:0]);
        put_byte(cnt[15:8]);
        put_byte(ZERO_BYTE);
        put_byte(ZERO_BYTE);
        put_byte(c.speed[7:0]);
        put_byte(c.speed[15:8]);
        send_packet();
      end
      OP_RD_POS, OP_RD_TRQ: begin
        if (c.id >= 1 && c.id <= MAX_ID_DEF) begin
          armed = (c.op == OP_RD_POS) ? ARM_POS : ARM_TRQ;
          pend_servo = c.id;
          reply_cnt = 0;
          put_byte(HDR_BYTE);
          put_byte(HDR_BYTE);
          put_byte(c.id);
          put_byte(LEN_READ);
          put_byte(INS_READ);
          put_byte((c.op == OP_RD_POS) ? REG_POSITION : REG_LOAD);
          put_byte(READ_LEN);
          send_packet();
        end
      end
      OP_REPLY: begin
        // Reply bytes only matter while a read is pending.
        if (armed != ARM_NONE) begin
          if (reply_cnt == REPLY_LOW_POS) begin
            reply_lo = c.rx;
            reply_cnt++;
          end else if (reply_cnt == REPLY_HIGH_POS) begin
            if (armed == ARM_POS) begin
              pos_store[pend_servo] = {c.rx, reply_lo};
            end else if (c.rx <= TRQ_HI_MAX) begin
              // Sign-magnitude load: bit 2 of the high byte is the sign.
              mag = {1'b0, c.rx[1:0], reply_lo};
              trq_store[pend_servo] = c.rx[2] ? (11'd0 - mag) : mag;
            end
            reply_cnt++;
            push_result(KIND_REPLY, '0, 1'b0, pend_servo[ID_W-1:0], pos_store[pend_servo],
                        trq_store[pend_servo]);
          end else if (reply_cnt >= REPLY_END_POS) begin
            armed = ARM_NONE;
            reply_cnt = 0;
          end else begin
            reply_cnt++;
          end
        end
      end
      OP_QUERY: begin
        p = '0;
        t = '0;
        if (c.id >= 1 && c.id <= MAX_ID_DEF) begin
          p = pos_store[c.id];
          t = trq_store[c.id];
        end
        push_result(KIND_QUERY, '0, 1'b0, c.id, p, t);
      end
      default: begin
      end
    endcase
  endtask

  // Driver: sends queued commands in bursts with random gaps between them.
  always @(posedge clk) begin : drive
    servo_cmd_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        // A transfer happens at this edge.
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) :
                       $urandom_range(1, 8);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        nxt = cmd_q.pop_front();
        start <= 1'b1;
        in_operation <= nxt.op;
        in_servo_id <= nxt.id;
        in_angle_centideg <= nxt.angle;
        in_speed <= nxt.speed;
        in_accel <= nxt.accel;
        in_rx_byte <= nxt.rx;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each result against the oldest prediction, then predicts new transfers.
  always @(posedge clk) begin : monitor
    bus_result_t got;
    bus_result_t want;
    servo_cmd_t  acc;
    if (!rst_n) begin
      reset_model();
    end else begin
      if (out_valid) begin
        got.kind = kind_t'(out_kind);
        got.tx = out_tx_byte;
        got.last = out_last;
        got.id = out_reading_id;
        got.pos = out_position_count;
        got.trq = out_torque;
        case (got.kind)
          KIND_TX:    if (got.last) n_packets++;
          KIND_REPLY: n_decoded++;
          default:    n_answers++;
        endcase
        if (predicted_out_q.size() == 0) begin
          flag_error($sformatf("unexpected result kind=%0d tx=%02h last=%0d id=%0d pos=%0d trq=%0d",
                               got.kind, got.tx, got.last, got.id, got.pos, $signed(got.trq)));
        end else begin
          want = predicted_out_q.pop_front();
          if (got.kind != want.kind || got.tx != want.tx || got.last != want.last ||
              got.id != want.id || got.pos != want.pos || got.trq != want.trq) begin
            flag_error($sformatf({"mismatch: expected kind=%0d tx=%02h last=%0d id=%0d pos=%0d ",
                                  "trq=%0d, got kind=%0d tx=%02h last=%0d id=%0d pos=%0d trq=%0d"},
                                 want.kind, want.tx, want.last, want.id, want.pos,
                                 $signed(want.trq), got.kind, got.tx, got.last, got.id, got.pos,
                                 $signed(got.trq)));
          end
        end
      end
      if (cfg_we) begin
        cpt_model = cfg_wdata;
      end
      if (start && !busy) begin
        acc.op = in_operation;
        acc.id = in_servo_id;
        acc.angle = in_angle_centideg;
        acc.speed = in_speed;
        acc.accel = in_accel;
        acc.rx = in_rx_byte;
        n_accepted++;
        predict_command(acc);
      end
    end
  end

  function automatic int rnd_byte();
    return $urandom_range(0, 255);
  endfunction

  function automatic int rnd_word();
    return $urandom_range(0, 65535);
  endfunction

  function automatic int rnd_angle();
    case ($urandom_range(0, 9))
      0:       return -36000;
      1:       return 36000;
      default: return int'($urandom_range(0, 72000)) - 36000;
    endcase
  endfunction

  task automatic push_cmd(logic [OP_W-1:0] op, int id, int ang, int spd, int acc, int rx);
    servo_cmd_t c;
    c.op = op;
    c.id = id;
    c.angle = ang;
    c.speed = spd;
    c.accel = acc;
    c.rx = rx;
    cmd_q.push_back(c);
  endtask

  // A read request followed by a number of reply bytes shaped like a real reply.
  task automatic push_read(bit torque_read, int id, int n_bytes);
    int b;
    push_cmd(torque_read ? OP_RD_TRQ : OP_RD_POS, id, rnd_angle(), rnd_word(), rnd_byte(),
             rnd_byte());
    for (int i = 0; i < n_bytes; i++) begin
      b = rnd_byte();
      if ($urandom_range(0, 3) != 0) begin
        case (i)
          0, 1: b = HDR_BYTE;
          2:    b = id;
          3:    b = LEN_READ;
          4:    b = 0;
          default: begin
          end
        endcase
      end
      if (i == REPLY_HIGH_POS && torque_read && $urandom_range(0, 4) != 0) begin
        b = $urandom_range(0, 7);
      end
      push_cmd(OP_REPLY, rnd_byte(), rnd_angle(), rnd_word(), rnd_byte(), b);
    end
  endtask

  // Moves around the rounding points and the angle limits.
  task automatic rounding_moves();
    push_cmd(OP_MOVE, rnd_byte(), 18000, rnd_word(), rnd_byte(), rnd_byte());
    push_cmd(OP_MOVE_ACC, rnd_byte(), -18000, rnd_word(), rnd_byte(), rnd_byte());
    push_cmd(OP_MOVE, rnd_byte(), 17999, rnd_word(), rnd_byte(), rnd_byte());
    push_cmd(OP_MOVE_ACC, rnd_byte(), -36000, rnd_word(), rnd_byte(), rnd_byte());
  endtask

  // Mostly complete read sequences with random content, plus moves, queries and noise.
  task automatic random_traffic(int budget);
    int done;
    int pick;
    int id;
    int n_bytes;
    done = 0;
    while (done < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
        push_cmd(OP_MOVE, rnd_byte(), rnd_angle(), rnd_word(), rnd_byte(), rnd_byte());
        done++;
      end else if (pick < 32) begin
        push_cmd(OP_MOVE_ACC, rnd_byte(), rnd_angle(), rnd_word(), rnd_byte(), rnd_byte());
        done++;
      end else if (pick < 58) begin
        // Complete reply, now and then with stray bytes after it.
        n_bytes = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 10) : 8;
        push_read($urandom_range(0, 1), $urandom_range(1, MAX_ID_DEF), n_bytes);
        done += 9;
      end else if (pick < 68) begin
        // Reply cut short; a later read restarts the decoder, a move disarms it, stray reply bytes run it on.
        n_bytes = $urandom_range(0, 7);
        push_read($urandom_range(0, 1), $urandom_range(1, MAX_ID_DEF), n_bytes);
        done += 1 + n_bytes;
      end else if (pick < 80) begin
        id = ($urandom_range(0, 3) == 0) ? rnd_byte() : $urandom_range(0, MAX_ID_DEF + 1);
        push_cmd(OP_QUERY, id, rnd_angle(), rnd_word(), rnd_byte(), rnd_byte());
        done++;
      end else if (pick < 86) begin
        id = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(MAX_ID_DEF + 1, 255);
        push_cmd($urandom_range(0, 1) ? OP_RD_TRQ : OP_RD_POS, id, rnd_angle(), rnd_word(),
                 rnd_byte(), rnd_byte());
      end else if (pick < 94) begin
        push_cmd(OP_REPLY, rnd_byte(), rnd_angle(), rnd_word(), rnd_byte(), rnd_byte());
      end else begin
        push_cmd($urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO, rnd_byte(), rnd_angle(),
                 rnd_word(), rnd_byte(), rnd_byte());
      end
    end
  endtask

  // Hold off until every command is sent, every result is in and the block has settled.
  task automatic wait_idle();
    @(negedge clk);
    while (cmd_q.size() != 0 || start || busy || predicted_out_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (24) @(negedge clk);
  endtask

  task automatic write_cpt(logic [CPT_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CPT_W-1:0] cpt_set [0:4];
    int               waited;
    cpt_set[0] = 16'd65535;
    cpt_set[1] = 16'd1;
    cpt_set[2] = 16'd0;
    cpt_set[3] = 16'd36000;
    cpt_set[4] = $urandom_range(2, 65534);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening with the reset value of counts per turn.
    push_cmd(OP_QUERY, 1, 0, 0, 0, 0);
    push_cmd(OP_MOVE, 0, 36000, 16'hFFFF, 0, 0);
    push_cmd(OP_MOVE, 255, -36000, 0, 255, 255);
    push_cmd(OP_MOVE_ACC, 1, 0, 16'h1234, 0, 0);
    push_cmd(OP_MOVE_ACC, 254, -1, 16'h00FF, 255, 0);
    push_cmd(OP_REPLY, 3, 5, 0, 0, 8'hA5);
    push_cmd(OP_RD_POS, 0, 0, 0, 0, 0);
    push_cmd(OP_RD_TRQ, MAX_ID_DEF + 1, 0, 0, 0, 0);
    // Torque read of the top id ending in the most negative load.
    push_cmd(OP_RD_TRQ, MAX_ID_DEF, 0, 0, 0, 0);
    push_cmd(OP_REPLY, 0, 0, 0, 0, HDR_BYTE);
    push_cmd(OP_REPLY, 0, 0, 0, 0, HDR_BYTE);
    push_cmd(OP_REPLY, 0, 0, 0, 0, MAX_ID_DEF);
    push_cmd(OP_REPLY, 0, 0, 0, 0, LEN_READ);
    push_cmd(OP_REPLY, 0, 0, 0, 0, 0);
    push_cmd(OP_REPLY, 0, 0, 0, 0, 8'hFF);
    push_cmd(OP_REPLY, 0, 0, 0, 0, TRQ_HI_MAX);
    push_cmd(OP_REPLY, 0, 0, 0, 0, 8'h00);
    push_cmd(OP_QUERY, MAX_ID_DEF, 0, 0, 0, 0);
    push_cmd(OP_QUERY, 0, 0, 0, 0, 0);
    push_cmd(OP_QUERY, 255, 0, 0, 0, 0);
    push_cmd(OP_SPARE_LO, 2, 0, 0, 0, 0);
    push_cmd(OP_SPARE_HI, 2, 0, 0, 0, 0);
    random_traffic(60);

    // Further phases, each under its own counts-per-turn setting.
    for (int k = 0; k < 5; k++) begin
      wait_idle();
      write_cpt(cpt_set[k]);
      @(negedge clk);
      rounding_moves();
      random_traffic(55);
    end

    // Drain, with a bound on how long the last results may take.
    waited = 0;
    @(negedge clk);
    while ((cmd_q.size() != 0 || start || predicted_out_q.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (24) @(negedge clk);
    if (predicted_out_q.size() != 0) begin
      flag_error($sformatf("%0d predicted results never arrived", predicted_out_q.size()));
    end

    $display("Run covered %0d commands: %0d packets, %0d decoded replies, %0d query answers,",
             n_accepted, n_packets, n_decoded, n_answers);
    $display("under six counts-per-turn settings including 0, 1, 4096 and 65535; errors: %0d",
             errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
